// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant check failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// File: hw/rtl/tpfir9_pkg.sv
// constants shared by the three-parallel nine-tap fir
package tpfir9_pkg;

	localparam int TAPS      = 9;
	localparam int HISTORY   = 8;
	localparam int LANES     = 3;
	localparam int WIN       = HISTORY + LANES;
	localparam int OUT_BITS  = 13;
	localparam int COEF_BITS = 12;

	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic signed [OUT_BITS-1:0] out_t;

	localparam coef_t COEFS [TAPS] = '{
		-12'sd13, -12'sd28, 12'sd104, 12'sd544, 12'sd830,
		12'sd544, 12'sd104, -12'sd28, -12'sd13
	};

endpackage

// File: hw/rtl/tpfir9_in_if.sv
// input channel: three consecutive samples per transaction
interface tpfir9_in_if #(
	parameter int SAMPLE_BITS = 12
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_oldest;
	logic signed [SAMPLE_BITS-1:0] sample_middle;
	logic signed [SAMPLE_BITS-1:0] sample_newest;

	modport source (output valid, sample_oldest, sample_middle, sample_newest, input ready);
	modport sink (input valid, sample_oldest, sample_middle, sample_newest, output ready);
endinterface

// File: hw/rtl/tpfir9_out_if.sv
// output channel: three filter outputs per transaction
interface tpfir9_out_if ();
	logic                                    valid;
	logic                                    ready;
	logic signed [tpfir9_pkg::OUT_BITS-1:0] filtered_oldest;
	logic signed [tpfir9_pkg::OUT_BITS-1:0] filtered_middle;
	logic signed [tpfir9_pkg::OUT_BITS-1:0] filtered_newest;

	modport source (output valid, filtered_oldest, filtered_middle, filtered_newest, input ready);
	modport sink (input valid, filtered_oldest, filtered_middle, filtered_newest, output ready);
endinterface

// File: hw/rtl/tpfir9_history.sv
// sample delay line that shifts by three per transaction and forms the window
module tpfir9_history #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic signed [SAMPLE_BITS-1:0] new_samples [tpfir9_pkg::LANES],
	output logic signed [SAMPLE_BITS-1:0] win [tpfir9_pkg::WIN]
);
	localparam int HISTORY = tpfir9_pkg::HISTORY;
	localparam int LANES   = tpfir9_pkg::LANES;

	// oldest first
	logic signed [SAMPLE_BITS-1:0] hist_q [HISTORY];

	for (genvar j = 0; j < HISTORY; j++) begin : g_old
		assign win[j] = hist_q[j];
	end
	for (genvar p = 0; p < LANES; p++) begin : g_new
		assign win[HISTORY + p] = new_samples[p];
	end

	for (genvar j = 0; j < HISTORY; j++) begin : g_shift
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hist_q[j] <= '0;
			end else if (load) begin
				hist_q[j] <= win[j + LANES];
			end
		end
	end
endmodule

// File: hw/rtl/tpfir9_tap_cell.sv
// one tap of the filter: adds its three floored products to the running sums
module tpfir9_tap_cell #(
	parameter int SAMPLE_BITS   = 12,
	parameter int PRODUCT_SHIFT = 16,
	parameter int TAP           = 0
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [SAMPLE_BITS-1:0]           in_win [tpfir9_pkg::WIN],
	input  logic signed [tpfir9_pkg::OUT_BITS-1:0] in_sum [tpfir9_pkg::LANES],
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [SAMPLE_BITS-1:0]           out_win [tpfir9_pkg::WIN],
	output logic signed [tpfir9_pkg::OUT_BITS-1:0] out_sum [tpfir9_pkg::LANES]
);
	localparam int WIN         = tpfir9_pkg::WIN;
	localparam int LANES       = tpfir9_pkg::LANES;
	localparam int OUT_BITS    = tpfir9_pkg::OUT_BITS;
	localparam int PROD_W      = SAMPLE_BITS + tpfir9_pkg::COEF_BITS;
	localparam int EXT_W       = PROD_W + OUT_BITS;
	localparam int SCALE_RAW   = PRODUCT_SHIFT - SAMPLE_BITS + 1;
	localparam int SCALE_SHIFT = (SCALE_RAW < 0) ? 0 : SCALE_RAW;
	localparam tpfir9_pkg::coef_t COEF = tpfir9_pkg::COEFS[TAP];

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] win_s1 [WIN];
	logic signed [OUT_BITS-1:0]    sum_s1 [LANES];
	logic signed [OUT_BITS-1:0]    sum_next [LANES];
	logic                          load;

	for (genvar p = 0; p < LANES; p++) begin : g_lane
		localparam int IDX = tpfir9_pkg::HISTORY + p - TAP;
		logic signed [PROD_W-1:0] prod;
		logic signed [PROD_W-1:0] floored;
		logic signed [EXT_W-1:0]  ext;
		logic signed [OUT_BITS-1:0] term;

		always_comb begin
			prod    = PROD_W'(in_win[IDX]) * PROD_W'(COEF);
			// arithmetic shift floors toward minus infinity
			floored = prod >>> PRODUCT_SHIFT;
			ext     = EXT_W'(floored);
			term    = OUT_BITS'(ext <<< SCALE_SHIFT);
		end

		assign sum_next[p] = in_sum[p] + term;
	end

	assign load     = !valid_s1 || out_ready;
	assign in_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			win_s1 <= in_win;
			sum_s1 <= sum_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_win   = win_s1;
	assign out_sum   = sum_s1;
endmodule

// File: hw/rtl/three_parallel_fir_9tap.sv
// top level of the three-parallel nine-tap symmetric low-pass fir
// Usage:
//   samples (sink): each transaction carries three consecutive signed samples,
//   oldest first. filtered (source): one transaction per input transaction with
//   the three filter outputs for those sample times, in the same order.
//   Coefficients are -13 -28 104 544 830 544 104 -28 -13; each product is floored
//   by PRODUCT_SHIFT bits and rescaled before the nine terms are summed.
// Throughput: one transaction per cycle while filtered.ready is high; each of the
//   nine tap cells holds one transaction and hands its partial sums and sample
//   window on, the last cell driving filtered.
// Reset: arst_n clears the eight-sample delay line to zero and empties the cells.
// Stall: when filtered.ready is low the last cell holds its result; earlier
//   cells keep filling until every cell is occupied, then samples.ready drops.
module three_parallel_fir_9tap #(
	parameter int SAMPLE_BITS   = 12,
	parameter int PRODUCT_SHIFT = 16
) (
	input logic         clk,
	input logic         arst_n,
	tpfir9_in_if.sink   samples,
	tpfir9_out_if.source filtered
);
	localparam int TAPS     = tpfir9_pkg::TAPS;
	localparam int LANES    = tpfir9_pkg::LANES;
	localparam int WIN      = tpfir9_pkg::WIN;
	localparam int OUT_BITS = tpfir9_pkg::OUT_BITS;

	logic                          vld [TAPS+1];
	logic                          rdy [TAPS+1];
	logic signed [OUT_BITS-1:0]    sum [TAPS+1][LANES];
	logic signed [SAMPLE_BITS-1:0] win [TAPS][WIN];
	logic signed [SAMPLE_BITS-1:0] new_samples [LANES];

	assign new_samples[0] = samples.sample_oldest;
	assign new_samples[1] = samples.sample_middle;
	assign new_samples[2] = samples.sample_newest;

	tpfir9_history #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_history (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (samples.valid && rdy[0]),
		.new_samples(new_samples),
		.win        (win[0])
	);

	assign vld[0]        = samples.valid;
	assign samples.ready = rdy[0];

	for (genvar p = 0; p < LANES; p++) begin : g_zero
		assign sum[0][p] = '0;
	end

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		if (k < TAPS - 1) begin : g_mid
			tpfir9_tap_cell #(
				.SAMPLE_BITS  (SAMPLE_BITS),
				.PRODUCT_SHIFT(PRODUCT_SHIFT),
				.TAP          (k)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_valid (vld[k]),
				.in_ready (rdy[k]),
				.in_win   (win[k]),
				.in_sum   (sum[k]),
				.out_valid(vld[k+1]),
				.out_ready(rdy[k+1]),
				.out_win  (win[k+1]),
				.out_sum  (sum[k+1])
			);
		end else begin : g_last
			// the last cell's register is the output register
			tpfir9_tap_cell #(
				.SAMPLE_BITS  (SAMPLE_BITS),
				.PRODUCT_SHIFT(PRODUCT_SHIFT),
				.TAP          (k)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_valid (vld[k]),
				.in_ready (rdy[k]),
				.in_win   (win[k]),
				.in_sum   (sum[k]),
				.out_valid(vld[k+1]),
				.out_ready(rdy[k+1]),
				.out_win  (),
				.out_sum  (sum[k+1])
			);
		end
	end

	assign rdy[TAPS]                = filtered.ready;
	assign filtered.valid           = vld[TAPS];
	assign filtered.filtered_oldest = sum[TAPS][0];
	assign filtered.filtered_middle = sum[TAPS][1];
	assign filtered.filtered_newest = sum[TAPS][2];
endmodule

// File: hw/rtl/tpfir9_checker.sv
// port-level checks for the three-parallel fir, bound to the top level
`include "assert_macros.svh"

module tpfir9_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    samples_valid,
	input logic                                    samples_ready,
	input logic                                    filtered_valid,
	input logic                                    filtered_ready,
	input logic signed [tpfir9_pkg::OUT_BITS-1:0] filtered_oldest,
	input logic signed [tpfir9_pkg::OUT_BITS-1:0] filtered_middle,
	input logic signed [tpfir9_pkg::OUT_BITS-1:0] filtered_newest
);
	localparam int DEPTH = tpfir9_pkg::TAPS;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] inflight_q;
	logic             in_xfer;
	logic             out_xfer;

	assign in_xfer  = samples_valid && samples_ready;
	assign out_xfer = filtered_valid && filtered_ready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, filtered_valid && !filtered_ready, filtered_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, filtered_valid && !filtered_ready, $stable(filtered_oldest) && $stable(filtered_middle) && $stable(filtered_newest))
	`ASSERT_ALWAYS(a_depth, clk, arst_n, inflight_q <= CNT_W'(DEPTH))
	`ASSERT_IMPLIES(a_no_spurious, clk, arst_n, filtered_valid, inflight_q != '0)
	`ASSERT_IMPLIES(a_room_ready, clk, arst_n, inflight_q < CNT_W'(DEPTH), samples_ready)
endmodule

bind three_parallel_fir_9tap tpfir9_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.samples_valid  (samples.valid),
	.samples_ready  (samples.ready),
	.filtered_valid (filtered.valid),
	.filtered_ready (filtered.ready),
	.filtered_oldest(filtered.filtered_oldest),
	.filtered_middle(filtered.filtered_middle),
	.filtered_newest(filtered.filtered_newest)
);
